>>> src/soc_pkg.sv
// shared types and constants for the sorted occurrence counter
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

  localparam int SOC_DEPTH_DEF = 64;
  localparam int KIND_W        = 2;
  localparam int VALUE_W       = 32;
  localparam int IDX_W         = 6;
  localparam int FREQ_W        = 7;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // strobes broadcast from the controller to every cell
  typedef struct packed {
    logic ins;    // sorted insert of the broadcast key
    logic ld;     // capture compare flags against the held key
    logic shift;  // move flags one cell toward cell 0
  } soc_ctl_t;

endpackage

`default_nettype wire

>>> src/soc_cell.sv
// one cell of the sorted chain: holds one value and its query flags
`timescale 1ns / 1ps
`default_nettype none

module soc_cell (
  input  logic                                 clk,
  input  soc_pkg::soc_ctl_t                    ctl,
  input  logic                                 cell_valid,
  input  logic signed [soc_pkg::VALUE_W-1:0]   key,
  input  logic                                 left_gt,
  input  logic signed [soc_pkg::VALUE_W-1:0]   left_val,
  input  logic                                 right_lt,
  input  logic                                 right_eq,
  output logic                                 gt,
  output logic signed [soc_pkg::VALUE_W-1:0]   val,
  output logic                                 lt_flag,
  output logic                                 eq_flag
);
  import soc_pkg::*;

  logic signed [VALUE_W-1:0] val_r;
  logic                      lt_r;
  logic                      eq_r;

  // empty cells act as +infinity so the new value lands at the end of the run
  assign gt      = !cell_valid || (val_r > key);
  assign val     = val_r;
  assign lt_flag = lt_r;
  assign eq_flag = eq_r;

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      val_r <= left_gt ? left_val : key;
    end
    if (ctl.ld) begin
      lt_r <= cell_valid && (val_r < key);
      eq_r <= cell_valid && (val_r == key);
    end else if (ctl.shift) begin
      lt_r <= right_lt;
      eq_r <= right_eq;
    end
  end

endmodule

`default_nettype wire

>>> src/sorted_occurrence_counter_top.sv
// top level of the sorted occurrence counter: cell chain and controller
// The store is a chain of DEPTH cells kept in ascending order at all times: an append
// is a sorted insert (larger values step one cell right) and a clear empties the store,
// and neither gives a result; appends to a full store are dropped. A query compares
// every cell against the value in the load state, then shifts the less-than and equal
// flags down the chain into two counters, one cell per cycle, so a query holds the
// input through transfer, compare, the shift of every cell and the result load, plus
// any wait on the output register. The result register lets the next item be taken
// while a result waits. Positions are reported modulo 64 when DEPTH exceeds 64, and
// frequency modulo 128 when DEPTH exceeds 127.
`timescale 1ns / 1ps
`default_nettype none

module sorted_occurrence_counter_top #(
  parameter int DEPTH = soc_pkg::SOC_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [soc_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [soc_pkg::VALUE_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic [soc_pkg::IDX_W-1:0]            out_first_index,
  output logic [soc_pkg::IDX_W-1:0]            out_last_index,
  output logic [soc_pkg::FREQ_W-1:0]           out_frequency
);
  import soc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);
  localparam int RW = (CW > FREQ_W) ? CW : FREQ_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r;
  logic signed [VALUE_W-1:0] key_r;
  logic [SW-1:0]             scan_r;
  logic [CW-1:0]             lt_acc_r;
  logic [CW-1:0]             eq_acc_r;
  logic                      out_valid_r;
  logic                      found_r;
  logic [IDX_W-1:0]          first_r;
  logic [IDX_W-1:0]          last_r;
  logic [FREQ_W-1:0]         freq_r;

  soc_ctl_t                  ctl;
  logic                      accept;
  logic signed [VALUE_W-1:0] cell_key;
  logic                      gt_w  [DEPTH];
  logic signed [VALUE_W-1:0] val_w [DEPTH];
  logic                      lt_w  [DEPTH];
  logic                      eq_w  [DEPTH];
  logic                      res_found;
  logic [RW-1:0]             first_w;
  logic [RW-1:0]             freq_w;
  logic [RW-1:0]             last_w;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign ctl.ins   = accept && (in_kind == KIND_APPEND) && (count_r < CW'(DEPTH));
  assign ctl.ld    = (state_r == ST_LOAD);
  assign ctl.shift = (state_r == ST_SCAN);
  assign cell_key  = ctl.ins ? in_value : key_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_gt;
    logic signed [VALUE_W-1:0] l_val;
    logic                      r_lt;
    logic                      r_eq;

    if (i == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_val = '0;
    end else begin : g_body
      assign l_gt  = gt_w[i-1];
      assign l_val = val_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_lt = 1'b0;
      assign r_eq = 1'b0;
    end else begin : g_next
      assign r_lt = lt_w[i+1];
      assign r_eq = eq_w[i+1];
    end

    soc_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_valid (CW'(i) < count_r),
      .key        (cell_key),
      .left_gt    (l_gt),
      .left_val   (l_val),
      .right_lt   (r_lt),
      .right_eq   (r_eq),
      .gt         (gt_w[i]),
      .val        (val_w[i]),
      .lt_flag    (lt_w[i]),
      .eq_flag    (eq_w[i])
    );
  end

  // first position is the count of smaller values, the run length is the equal count
  assign res_found = (eq_acc_r != '0);
  assign first_w   = RW'(lt_acc_r);
  assign freq_w    = RW'(eq_acc_r);
  assign last_w    = first_w + freq_w - RW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_QUERY)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_r == SW'(DEPTH - 1)) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (ctl.ins) begin
        count_r <= count_r + CW'(1);
      end else if (accept && (in_kind == KIND_CLEAR)) begin
        count_r <= '0;
      end

      if (accept && (in_kind == KIND_QUERY)) begin
        key_r <= in_value;
      end

      if (ctl.ld) begin
        scan_r   <= '0;
        lt_acc_r <= '0;
        eq_acc_r <= '0;
      end else if (ctl.shift) begin
        scan_r   <= scan_r + SW'(1);
        lt_acc_r <= lt_acc_r + CW'(lt_w[0]);
        eq_acc_r <= eq_acc_r + CW'(eq_w[0]);
      end

      if (state_r == ST_RESULT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        found_r     <= res_found;
        first_r     <= res_found ? first_w[IDX_W-1:0] : '0;
        last_r      <= res_found ? last_w[IDX_W-1:0] : '0;
        freq_r      <= res_found ? freq_w[FREQ_W-1:0] : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_first_index = first_r;
  assign out_last_index  = last_r;
  assign out_frequency   = freq_r;

endmodule

`default_nettype wire

>>> src/soc_checker.sv
// port-level checks for the sorted occurrence counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module soc_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic [soc_pkg::KIND_W-1:0]           in_kind,
  input wire logic signed [soc_pkg::VALUE_W-1:0]   in_value,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic                                 out_found,
  input wire logic [soc_pkg::IDX_W-1:0]            out_first_index,
  input wire logic [soc_pkg::IDX_W-1:0]            out_last_index,
  input wire logic [soc_pkg::FREQ_W-1:0]           out_frequency
);
  import soc_pkg::*;

  // a pending result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a miss reports all-zero positions and count
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_first_index == '0 && out_last_index == '0 && out_frequency == '0)
    else $error("miss with nonzero fields");

  // a hit spans a consistent run
  a_hit_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      out_first_index <= out_last_index &&
      out_frequency == FREQ_W'({1'b0, out_last_index} - {1'b0, out_first_index} + 7'd1))
    else $error("hit with inconsistent positions");

  // a query transfer blocks input while the search runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
    else $error("input taken during a query");

endmodule

bind sorted_occurrence_counter_top soc_checker u_soc_checker (.*);

`default_nettype wire

>>> verif/sorted_occurrence_counter_top_tb.sv
// testbench for the sorted occurrence counter: queued driver, predictor and result monitor
`timescale 1ns / 1ps

module sorted_occurrence_counter_top_tb;

  import soc_pkg::*;

  localparam int DEPTH       = SOC_DEPTH_DEF;
  localparam int ITEMS       = 1500;
  localparam int PHASE_LEN   = 500;
  localparam int HOLD_AT     = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  last_index;
    logic [FREQ_W-1:0] frequency;
  } hit_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_kind  = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_found;
  logic [IDX_W-1:0]          out_first_index;
  logic [IDX_W-1:0]          out_last_index;
  logic [FREQ_W-1:0]         out_frequency;

  item_t                     pending_items[$];
  hit_t                      expected_hits[$];
  // predictor copy of the store, kept in ascending order
  logic signed [VALUE_W-1:0] sorted_store[$];

  int sent_count = 0;
  int fail_count = 0;
  int hold_left  = 0;
  logic hold_done = 1'b0;

  sorted_occurrence_counter_top #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index),
    .out_frequency   (out_frequency)
  );

  always #5 clk = ~clk;

  function automatic int tx_idle_pct(input int n);
    if (n < PHASE_LEN) return 35;
    if (n < 2 * PHASE_LEN) return 76;
    return 0;
  endfunction

  function automatic int rx_idle_pct(input int n);
    if (n < PHASE_LEN) return 76;
    if (n < 2 * PHASE_LEN) return 35;
    return 0;
  endfunction

  // position of the value in sorted order, from counts of smaller and equal entries
  function automatic hit_t locate_value(input logic signed [VALUE_W-1:0] v);
    hit_t h;
    int   lt;
    int   eq;
    h  = '0;
    lt = 0;
    eq = 0;
    foreach (sorted_store[i]) begin
      if (sorted_store[i] < v) lt++;
      else if (sorted_store[i] == v) eq++;
    end
    if (eq > 0) begin
      h.found       = 1'b1;
      h.first_index = IDX_W'(lt);
      h.last_index  = IDX_W'(lt + eq - 1);
      h.frequency   = FREQ_W'(eq);
    end
    return h;
  endfunction

  task automatic track_item(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] v);
    int pos;
    pos = 0;
    case (kind)
      KIND_APPEND: begin
        // full store drops the append
        if (sorted_store.size() < DEPTH) begin
          while (pos < sorted_store.size() && sorted_store[pos] <= v) pos++;
          sorted_store.insert(pos, v);
        end
      end
      KIND_QUERY: expected_hits.push_back(locate_value(v));
      KIND_CLEAR: sorted_store.delete();
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind  <= '0;
      in_value <= '0;
    end else begin
      if (in_valid && in_ready) begin
        track_item(in_kind, in_value);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct(sent_count)) begin
          it = pending_items.pop_front();
          in_kind  <= it.kind;
          in_value <= it.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off so the result register fills and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct(sent_count));
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result: found=%0d first=%0d last=%0d freq=%0d",
                   out_found, out_first_index, out_last_index, out_frequency);
        fail_count <= fail_count + 1;
      end else begin
        want = expected_hits.pop_front();
        if (out_found !== want.found || out_first_index !== want.first_index ||
            out_last_index !== want.last_index || out_frequency !== want.frequency) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: exp found=%0d first=%0d last=%0d freq=%0d, got %0d %0d %0d %0d",
                     want.found, want.first_index, want.last_index, want.frequency,
                     out_found, out_first_index, out_last_index, out_frequency);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value(input int mode);
    case (mode)
      0: return $signed($urandom_range(0, 8)) - 4;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0: return VAL_MIN;
          1: return VAL_MIN + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return VAL_MAX - 1;
          default: return VAL_MAX;
        endcase
      end
    endcase
  endfunction

  int planned = 0;

  task automatic add_item(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] v);
    item_t it;
    it.kind  = kind;
    it.value = v;
    pending_items.push_back(it);
    // ignored kinds do not count toward the item budget
    if (kind != KIND_UNUSED) planned++;
  endtask

  initial begin
    #10ms;
    $display("[sorted_occurrence_counter_top] ERROR");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] seq_vals[$];
    logic signed [VALUE_W-1:0] v;
    int r;
    int mode;
    int n;

    // directed: empty store, extremes, duplicates, ignored kind, clear
    add_item(KIND_QUERY, 5);
    add_item(KIND_APPEND, VAL_MAX);
    add_item(KIND_APPEND, VAL_MIN);
    add_item(KIND_APPEND, 0);
    add_item(KIND_APPEND, -1);
    add_item(KIND_APPEND, 0);
    add_item(KIND_APPEND, 0);
    add_item(KIND_QUERY, 0);
    add_item(KIND_QUERY, VAL_MIN);
    add_item(KIND_QUERY, VAL_MAX);
    add_item(KIND_QUERY, -1);
    add_item(KIND_QUERY, 1);
    add_item(KIND_UNUSED, 32'shffff_ffff);
    add_item(KIND_QUERY, VAL_MAX);
    add_item(KIND_CLEAR, 0);
    add_item(KIND_QUERY, 0);
    add_item(KIND_APPEND, 32'sh5555_5555);
    add_item(KIND_APPEND, 32'shaaaa_aaaa);
    add_item(KIND_QUERY, 32'shaaaa_aaaa);
    add_item(KIND_QUERY, 32'sh5555_5555);
    add_item(KIND_UNUSED, 0);
    add_item(KIND_CLEAR, VAL_MIN);
    add_item(KIND_QUERY, 32'sh5555_5555);

    // random: mostly fill-then-query sequences, some loose noise
    while (planned < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_item(KIND_UNUSED, $urandom);
      end else if (r < 10) begin
        add_item(KIND_CLEAR, $urandom);
      end else if (r < 14) begin
        add_item(KIND_QUERY, pick_value($urandom_range(0, 2)));
      end else begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 70) add_item(KIND_CLEAR, $urandom);
        // now and then run past a full store
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(1, 20);
        seq_vals.delete();
        repeat (n) begin
          v = pick_value(mode);
          seq_vals.push_back(v);
          add_item(KIND_APPEND, v);
        end
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) v = seq_vals[$urandom_range(0, seq_vals.size() - 1)];
          else v = pick_value(mode);
          add_item(KIND_QUERY, v);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);

    if (fail_count == 0 && expected_hits.size() == 0) begin
      $display("[sorted_occurrence_counter_top] OK");
    end else begin
      $display("[sorted_occurrence_counter_top] ERROR");
    end
    $finish;
  end

endmodule
